// File: hw/rtl/sfla_pkg.sv
// Shared constants, codes and types of the segregated free list allocator.
`default_nettype none

package sfla_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int NUM_CLASSES  = 12;
    localparam int MIN_BLOCK    = 8;
    localparam int HEADER_BYTES = 8;
    localparam int HDR_WORDS    = HEAP_BYTES / 8;
    localparam int HDR_AW       = $clog2(HDR_WORDS);

    // Class counter must hold NUM_CLASSES itself; the list index needs one less.
    localparam int CLS_W = $clog2(NUM_CLASSES + 1);
    localparam int IDX_W = $clog2(NUM_CLASSES);

    // Padded sizes and class sizes, and the wider compare operands.
    localparam int SZ_W  = 17;
    localparam int CMP_W = 18;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] CFG_MAX_SMALL = 2'd0;
    localparam logic [1:0] CFG_HEAP_BASE = 2'd1;
    localparam logic [1:0] CFG_HEAP_END  = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO      = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_NO_SPACE  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FREE_RD,
        S_CLASS,
        S_LIMIT,
        S_LOOKUP,
        S_POP,
        S_FREE_WR,
        S_RESP
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/segregated_free_list_allocator_core.sv
// Top level of the power-of-two segregated free list allocator.
//
// Usage: a request word enters on the slave stream. tuser carries the
// operation (0 allocate, 1 free); tdata carries the request size in bits
// 15:0 and the payload address of a block to free in bits 31:16. Every
// request answers with exactly one word on the master stream: tdata holds
// the returned payload address, tuser the status (0 ok, 1 zero size,
// 2 too large, 3 out of space). A free always answers address 0, status 0.
// Sequence: one request is in flight at a time. An allocate runs the size-class
// loop, k (1 to NUM_CLASSES + 1) passes, then the limit test and the list lookup,
// plus a pop when the block comes off a free list. A free reads the header, runs
// the same loop and limit test and links the block in. A refused allocate skips
// the lookup, an ignored free the link, and a zero-size request goes straight to
// its answer. The class loop runs one shared comparator and shifter once per
// cycle; the header memory has one read port and one write port.
// Reset: free lists empty, bump pointer 4096, max_small 4096, heap_end 65536.
// The header memory is not cleared; headers must be read only after they were
// written; the block does not enforce it. Configuration writes belong in idle periods.
// Stall: the result waits in an output register until the receiver takes
// it; the sequencer holds its finished result until that register frees.
`default_nettype none

module segregated_free_list_allocator_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave request stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,  // [15:0] request_size, [31:16] block_address
    input  wire logic        i_s_axis_tuser,  // [0] operation
    // Master result stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata,  // [15:0] result_address
    output logic [1:0]       o_m_axis_tuser,  // [1:0] status
    // Configuration write port.
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_wdata
);

    sfla_pkg::t_state  r_state, n_state;

    // Request and sequencer datapath.
    logic                       r_op,         n_op;
    logic [15:0]                r_haddr,      n_haddr;
    logic [sfla_pkg::SZ_W-1:0]  r_size,       n_size;
    logic [sfla_pkg::SZ_W-1:0]  r_s,          n_s;
    logic [sfla_pkg::CLS_W-1:0] r_cls,        n_cls;
    logic [15:0]                r_head,       n_head;
    logic [15:0]                r_res_addr,   n_res_addr;
    sfla_pkg::t_status          r_res_status, n_res_status;

    // Output register.
    logic                       r_out_valid,  n_out_valid;
    logic [15:0]                r_out_addr,   n_out_addr;
    sfla_pkg::t_status          r_out_status, n_out_status;

    // Allocator state and configuration.
    logic [16:0]                r_bump,       n_bump;
    logic [14:0]                r_max_small,  n_max_small;
    logic [16:0]                r_heap_end,   n_heap_end;
    logic [15:0]                r_heads [sfla_pkg::NUM_CLASSES];

    // Header memory, one word per 8-byte granule.
    logic [15:0]                r_hdr_mem [sfla_pkg::HDR_WORDS];
    logic [15:0]                r_rdata;

    logic                       mem_we, mem_re;
    logic [sfla_pkg::HDR_AW-1:0] mem_waddr, mem_raddr;
    logic [15:0]                mem_wdata;
    logic                       head_we;
    logic [15:0]                head_wdata;

    // Shared compare unit and the values that feed it.
    logic [sfla_pkg::CMP_W-1:0] cmp_a, cmp_b;
    logic                       cmp_lt;
    logic [sfla_pkg::CMP_W-1:0] bump_sum;
    logic [sfla_pkg::CMP_W-1:0] heap_limit;

    logic                       in_accept;
    logic                       out_free;
    logic                       cls_room;
    logic [sfla_pkg::IDX_W-1:0] cls_idx;
    logic [15:0]                in_haddr;
    logic [15:0]                base_aligned;

    assign o_s_axis_tready = (r_state == sfla_pkg::S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign cls_room        = (r_cls < sfla_pkg::CLS_W'(sfla_pkg::NUM_CLASSES));
    assign cls_idx         = r_cls[sfla_pkg::IDX_W-1:0];
    assign in_haddr        = i_s_axis_tdata[31:16] - 16'(sfla_pkg::HEADER_BYTES);

    assign bump_sum   = sfla_pkg::CMP_W'(r_bump) + sfla_pkg::CMP_W'(r_s);
    assign heap_limit = (sfla_pkg::CMP_W'(r_heap_end) < sfla_pkg::CMP_W'(sfla_pkg::HEAP_BYTES))
                      ? sfla_pkg::CMP_W'(r_heap_end)
                      : sfla_pkg::CMP_W'(sfla_pkg::HEAP_BYTES);

    // The one comparator: class loop test, class limit test, space test.
    always_comb begin
        case (r_state)
            sfla_pkg::S_LIMIT: begin
                cmp_a = sfla_pkg::CMP_W'(r_s);
                cmp_b = sfla_pkg::CMP_W'(r_max_small);
            end
            sfla_pkg::S_LOOKUP: begin
                cmp_a = heap_limit;
                cmp_b = bump_sum;
            end
            default: begin
                cmp_a = sfla_pkg::CMP_W'(r_s);
                cmp_b = sfla_pkg::CMP_W'(r_size);
            end
        endcase
    end
    assign cmp_lt = (cmp_a < cmp_b);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            sfla_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_s_axis_tuser == sfla_pkg::OP_FREE) begin
                        n_state = sfla_pkg::S_FREE_RD;
                    end else if (i_s_axis_tdata[15:0] == 16'd0) begin
                        n_state = sfla_pkg::S_RESP;
                    end else begin
                        n_state = sfla_pkg::S_CLASS;
                    end
                end
            end
            sfla_pkg::S_FREE_RD: n_state = sfla_pkg::S_CLASS;
            sfla_pkg::S_CLASS: begin
                if (!(cmp_lt && cls_room)) begin
                    n_state = sfla_pkg::S_LIMIT;
                end
            end
            sfla_pkg::S_LIMIT: begin
                if (!cls_room || !cmp_lt) begin
                    n_state = sfla_pkg::S_RESP;
                end else if (r_op == sfla_pkg::OP_FREE) begin
                    n_state = sfla_pkg::S_FREE_WR;
                end else begin
                    n_state = sfla_pkg::S_LOOKUP;
                end
            end
            sfla_pkg::S_LOOKUP: begin
                n_state = (r_head != 16'd0) ? sfla_pkg::S_POP : sfla_pkg::S_RESP;
            end
            sfla_pkg::S_POP:     n_state = sfla_pkg::S_RESP;
            sfla_pkg::S_FREE_WR: n_state = sfla_pkg::S_RESP;
            sfla_pkg::S_RESP: begin
                if (out_free) begin
                    n_state = sfla_pkg::S_IDLE;
                end
            end
            default: n_state = sfla_pkg::S_IDLE;
        endcase
    end

    assign base_aligned = (i_cfg_wdata[15:3] == 13'd0) ? 16'd8 : {i_cfg_wdata[15:3], 3'b000};

    // Datapath control and next values.
    always_comb begin
        n_op         = r_op;
        n_haddr      = r_haddr;
        n_size       = r_size;
        n_s          = r_s;
        n_cls        = r_cls;
        n_head       = r_head;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_bump       = r_bump;
        n_max_small  = r_max_small;
        n_heap_end   = r_heap_end;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_addr   = r_out_addr;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_waddr    = sfla_pkg::HDR_AW'(r_haddr >> 3);
        mem_wdata    = 16'(r_s);
        mem_re       = 1'b0;
        mem_raddr    = sfla_pkg::HDR_AW'(in_haddr >> 3);
        head_we      = 1'b0;
        head_wdata   = r_haddr;

        case (r_state)
            sfla_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_op         = i_s_axis_tuser;
                    n_haddr      = in_haddr;
                    n_size       = sfla_pkg::SZ_W'(i_s_axis_tdata[15:0])
                                 + sfla_pkg::SZ_W'(sfla_pkg::HEADER_BYTES);
                    n_s          = sfla_pkg::SZ_W'(sfla_pkg::MIN_BLOCK);
                    n_cls        = '0;
                    n_res_addr   = 16'd0;
                    n_res_status = sfla_pkg::ST_OK;
                    if (i_s_axis_tuser == sfla_pkg::OP_FREE) begin
                        mem_re = 1'b1;
                    end else if (i_s_axis_tdata[15:0] == 16'd0) begin
                        n_res_status = sfla_pkg::ST_ZERO;
                    end
                end
            end
            sfla_pkg::S_FREE_RD: begin
                n_size = sfla_pkg::SZ_W'(r_rdata);
            end
            sfla_pkg::S_CLASS: begin
                if (cmp_lt && cls_room) begin
                    n_s   = r_s << 1;
                    n_cls = r_cls + sfla_pkg::CLS_W'(1);
                end
            end
            sfla_pkg::S_LIMIT: begin
                if (!cls_room || !cmp_lt) begin
                    // A free of an oversized or bogus header is dropped quietly.
                    if (r_op == sfla_pkg::OP_ALLOC) begin
                        n_res_status = sfla_pkg::ST_TOO_LARGE;
                    end
                end else begin
                    n_head = r_heads[cls_idx];
                end
            end
            sfla_pkg::S_LOOKUP: begin
                if (r_head != 16'd0) begin
                    mem_re    = 1'b1;
                    mem_raddr = sfla_pkg::HDR_AW'(r_head >> 3);
                end else if (cmp_lt) begin
                    n_res_status = sfla_pkg::ST_NO_SPACE;
                end else begin
                    mem_we     = 1'b1;
                    mem_waddr  = sfla_pkg::HDR_AW'(r_bump[15:0] >> 3);
                    n_bump     = bump_sum[16:0];
                    n_res_addr = r_bump[15:0] + 16'(sfla_pkg::HEADER_BYTES);
                end
            end
            sfla_pkg::S_POP: begin
                head_we    = 1'b1;
                head_wdata = r_rdata;
                mem_we     = 1'b1;
                mem_waddr  = sfla_pkg::HDR_AW'(r_head >> 3);
                n_res_addr = r_head + 16'(sfla_pkg::HEADER_BYTES);
            end
            sfla_pkg::S_FREE_WR: begin
                // The freed header now links to the old list head.
                mem_we     = 1'b1;
                mem_wdata  = r_heads[cls_idx];
                head_we    = 1'b1;
                head_wdata = r_haddr;
            end
            sfla_pkg::S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_addr   = r_res_addr;
                    n_out_status = r_res_status;
                end
            end
            default: begin
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_index)
                sfla_pkg::CFG_MAX_SMALL: n_max_small = i_cfg_wdata[14:0];
                sfla_pkg::CFG_HEAP_BASE: n_bump      = {1'b0, base_aligned};
                sfla_pkg::CFG_HEAP_END:  n_heap_end  = i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Control state and allocator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sfla_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_bump      <= 17'd4096;
            r_max_small <= 15'd4096;
            r_heap_end  <= 17'd65536;
            for (int i = 0; i < sfla_pkg::NUM_CLASSES; i++) begin
                r_heads[i] <= 16'd0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_bump      <= n_bump;
            r_max_small <= n_max_small;
            r_heap_end  <= n_heap_end;
            if (head_we) begin
                r_heads[cls_idx] <= head_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_haddr      <= n_haddr;
        r_size       <= n_size;
        r_s          <= n_s;
        r_cls        <= n_cls;
        r_head       <= n_head;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_addr   <= n_out_addr;
        r_out_status <= n_out_status;
    end

    // Header memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hdr_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_hdr_mem[mem_raddr];
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_addr;
    assign o_m_axis_tuser  = r_out_status;

`ifndef ASSERT_OFF
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state != sfla_pkg::S_IDLE))
        else $error("sequencer stayed idle after accepting a request");

    a_cls_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfla_pkg::S_CLASS) |-> (r_cls <= sfla_pkg::CLS_W'(sfla_pkg::NUM_CLASSES)))
        else $error("class counter ran past the last class");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sfla_pkg::S_POP) |-> (r_head != 16'd0))
        else $error("pop from an empty free list");

    a_bump_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bump[2:0] == 3'd0))
        else $error("bump pointer lost its 8-byte alignment");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != sfla_pkg::ST_OK)) |-> (r_out_addr == 16'd0))
        else $error("failed request returned a nonzero address");
`endif

endmodule

`default_nettype wire

// File: tb/testbench.sv
// Self-checking stream testbench for the segregated free list allocator core.
`timescale 1ns / 1ps

module testbench;

    // One request word and the reply word the allocator owes for it.
    typedef struct {
        logic        op;
        logic [15:0] size;
        logic [15:0] baddr;
    } t_request;

    typedef struct {
        logic [15:0]       addr;
        sfla_pkg::t_status status;
    } t_reply;

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        req_tvalid = 1'b0;
    logic        req_tready;
    logic [31:0] req_tdata  = '0;
    logic        req_tuser  = sfla_pkg::OP_ALLOC;
    logic        rsp_tvalid;
    logic        rsp_tready = 1'b0;
    logic [15:0] rsp_tdata;
    logic [1:0]  rsp_tuser;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = sfla_pkg::CFG_MAX_SMALL;
    logic [16:0] cfg_wdata  = '0;

    segregated_free_list_allocator_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_tvalid),
        .o_s_axis_tready (req_tready),
        .i_s_axis_tdata  (req_tdata),
        .i_s_axis_tuser  (req_tuser),
        .o_m_axis_tvalid (rsp_tvalid),
        .i_m_axis_tready (rsp_tready),
        .o_m_axis_tdata  (rsp_tdata),
        .o_m_axis_tuser  (rsp_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow of the allocator: registers, list heads, bump pointer and the
    // header words. The header store also remembers which words were ever
    // written, so that the stimulus never frees a block whose header would
    // be read before anything was stored there.
    int unsigned cfg_max_small = 4096;
    int unsigned cfg_heap_base = 4096;
    int unsigned cfg_heap_end  = 65536;
    int unsigned bump_ptr      = 4096;
    bit [15:0]   list_head   [sfla_pkg::NUM_CLASSES];
    bit [15:0]   hdr_mem     [sfla_pkg::HDR_WORDS];
    bit          hdr_written [sfla_pkg::HDR_WORDS];

    t_request    pending_reqs[$];
    t_reply      expected_replies[$];
    logic [15:0] live_blocks[$];    // payload addresses handed out and not yet freed
    logic [15:0] freed_blocks[$];   // recent frees, reused for double frees

    int unsigned n_req_sent    = 0;
    int unsigned n_req_taken   = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_gap      = 0;
    int unsigned stall_left    = 0;
    bit          steady        = 1'b0;   // no idling on either side while set
    t_request    next_req;

    function automatic int unsigned hdr_slot(input int unsigned addr);
        return ((addr & 32'hFFFF) >> 3) % sfla_pkg::HDR_WORDS;
    endfunction

    // Rounds a padded size up to its class. Returns the class index, or -1
    // when the size or its class size reaches max_small or runs past the
    // largest class.
    function automatic int class_of(input int unsigned sz, output int unsigned csz);
        int unsigned s;
        int          c;
        s   = sfla_pkg::MIN_BLOCK;
        c   = 0;
        csz = 0;
        if (sz >= cfg_max_small) return -1;
        while (s < sz && c < sfla_pkg::NUM_CLASSES) begin
            s = s << 1;
            c++;
        end
        if (c >= sfla_pkg::NUM_CLASSES || s >= cfg_max_small) return -1;
        csz = s;
        return c;
    endfunction

    // Works out the reply to one accepted request and advances the shadow.
    task automatic predict_reply(input logic op, input logic [15:0] req,
                                 input logic [15:0] baddr);
        t_reply      rep;
        int          c;
        int unsigned csz;
        int unsigned addr;
        int unsigned lim;
        int unsigned haddr;
        bit          got;
        rep.addr   = '0;
        rep.status = sfla_pkg::ST_OK;
        if (op == sfla_pkg::OP_ALLOC) begin
            got = 1'b0;
            if (req == 0) begin
                rep.status = sfla_pkg::ST_ZERO;
            end else begin
                c = class_of(32'(req) + sfla_pkg::HEADER_BYTES, csz);
                if (c < 0) begin
                    rep.status = sfla_pkg::ST_TOO_LARGE;
                end else if (list_head[c] != 0) begin
                    // Pop: the header of the head block links to the next one.
                    addr         = list_head[c];
                    list_head[c] = hdr_mem[hdr_slot(addr)];
                    got          = 1'b1;
                end else begin
                    lim = (cfg_heap_end < sfla_pkg::HEAP_BYTES) ? cfg_heap_end
                                                                : sfla_pkg::HEAP_BYTES;
                    if (bump_ptr + csz > lim) begin
                        rep.status = sfla_pkg::ST_NO_SPACE;
                    end else begin
                        addr     = bump_ptr;
                        bump_ptr = (bump_ptr + csz) & 32'h1FFFF;
                        got      = 1'b1;
                    end
                end
            end
            if (got) begin
                hdr_mem[hdr_slot(addr)]     = 16'(csz);
                hdr_written[hdr_slot(addr)] = 1'b1;
                rep.addr = 16'(addr + sfla_pkg::HEADER_BYTES);
                live_blocks.push_back(rep.addr);
            end
        end else begin
            // A free answers address zero, status ok, whatever the header says.
            haddr = (32'(baddr) + 32'h10000 - sfla_pkg::HEADER_BYTES) & 32'hFFFF;
            c = class_of(hdr_mem[hdr_slot(haddr)], csz);
            if (c >= 0) begin
                hdr_mem[hdr_slot(haddr)]     = list_head[c];
                hdr_written[hdr_slot(haddr)] = 1'b1;
                list_head[c] = 16'(haddr);
            end
        end
        expected_replies.push_back(rep);
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request driver: one word on the bus at a time, held until taken.
    always @(negedge clk) begin
        if (rst_n && n_req_sent == n_req_taken) begin
            if (send_gap != 0) begin
                send_gap--;
                req_tvalid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
                next_req = pending_reqs.pop_front();
                req_tdata  <= {next_req.baddr, next_req.size};
                req_tuser  <= next_req.op;
                req_tvalid <= 1'b1;
                n_req_sent++;
                send_gap = steady ? 0 : pick_gap();
            end else begin
                req_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: ready most of the time, with stalls of random length.
    always @(negedge clk) begin
        if (stall_left != 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
        end else begin
            rsp_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    // Monitor: checks each result word against the oldest expectation,
    // then predicts the reply for a request word taken at the same edge.
    // A reply can never come out at the edge its own request goes in.
    always @(posedge clk) begin
        t_reply exp_rep;
        if (rst_n) begin
            if (rsp_tvalid && rsp_tready) begin
                if (expected_replies.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, expected none, got addr %h status %0d",
                             $time, rsp_tdata, rsp_tuser);
                end else begin
                    exp_rep = expected_replies.pop_front();
                    if (rsp_tdata !== exp_rep.addr) begin
                        mismatch_count++;
                        $display("%0t: result address mismatch, expected %h, got %h",
                                 $time, exp_rep.addr, rsp_tdata);
                    end
                    if (rsp_tuser !== exp_rep.status) begin
                        mismatch_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, exp_rep.status, rsp_tuser);
                    end
                end
            end
            if (req_tvalid && req_tready) begin
                predict_reply(req_tuser, req_tdata[15:0], req_tdata[31:16]);
                n_req_taken++;
            end
        end
    end

    task automatic push_alloc(input logic [15:0] sz);
        t_request r;
        r.op    = sfla_pkg::OP_ALLOC;
        r.size  = sz;
        r.baddr = 16'($urandom);   // ignored by an allocate
        pending_reqs.push_back(r);
    endtask

    task automatic push_free(input logic [15:0] a);
        t_request r;
        r.op    = sfla_pkg::OP_FREE;
        r.size  = 16'($urandom);   // ignored by a free
        r.baddr = a;
        pending_reqs.push_back(r);
    endtask

    // Waits until every queued request word has been taken by the block.
    task automatic wait_requests_taken();
        while (pending_reqs.size() != 0 || n_req_sent != n_req_taken) @(posedge clk);
    endtask

    // Waits until the block has answered everything it was given.
    task automatic wait_idle();
        while (pending_reqs.size() != 0 || n_req_sent != n_req_taken ||
               expected_replies.size() != 0) @(posedge clk);
    endtask

    // Register write while the block is idle; the shadow follows at once.
    task automatic write_reg(input logic [1:0] idx, input logic [16:0] val);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        case (idx)
            sfla_pkg::CFG_MAX_SMALL: begin
                cfg_max_small = val & 17'h7FFF;
            end
            sfla_pkg::CFG_HEAP_BASE: begin
                // Base is forced to a nonzero multiple of eight and reloads
                // the bump pointer.
                cfg_heap_base = val & 17'hFFF8;
                if (cfg_heap_base == 0) cfg_heap_base = 8;
                bump_ptr = cfg_heap_base;
            end
            sfla_pkg::CFG_HEAP_END: begin
                cfg_heap_end = val;
            end
            default: begin
            end
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Payload sizes spread over the classes, small ones most often.
    function automatic logic [15:0] pick_size();
        int unsigned top;
        top = 1 << $urandom_range(3, ($urandom_range(0, 9) == 0) ? 14 : 10);
        return 16'($urandom_range(1, top));
    endfunction

    // Free address whose header word is known to hold something: either a
    // random hit or a live block with random low bits.
    function automatic logic [15:0] pick_stray_address();
        logic [15:0] a;
        int unsigned k;
        for (k = 0; k < 8; k++) begin
            a = 16'($urandom);
            if (hdr_written[hdr_slot(32'(a) + 32'h10000 - sfla_pkg::HEADER_BYTES)]) return a;
        end
        k = $urandom_range(0, live_blocks.size() - 1);
        return live_blocks[k] + 16'($urandom_range(0, 7));
    endfunction

    task automatic add_random_request();
        int unsigned r;
        int unsigned k;
        logic [15:0] a;
        r = $urandom_range(0, 99);
        if (r < 3) begin
            push_alloc(16'd0);
        end else if (r < 8) begin
            push_alloc(16'($urandom));
        end else if (r < 55 || live_blocks.size() == 0) begin
            push_alloc(pick_size());
        end else if (r < 90) begin
            k = $urandom_range(0, live_blocks.size() - 1);
            a = live_blocks[k];
            live_blocks.delete(k);
            freed_blocks.push_back(a);
            if (freed_blocks.size() > 64) freed_blocks.delete(0);
            push_free(a);
        end else if (r < 95 && freed_blocks.size() != 0) begin
            push_free(freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
        end else begin
            push_free(pick_stray_address());
        end
    endtask

    initial begin
        logic [15:0] blk_small;
        logic [15:0] blk_mid;
        logic [15:0] blk_big;
        int unsigned round;
        int unsigned n;
        int unsigned j;
        int unsigned batch;
        int unsigned base_val;
        int unsigned end_val;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part, reset settings first: zero size, the smallest
        // classes, a class rounding up to max_small, a padded size equal to
        // max_small and an all-ones size.
        push_alloc(16'd0);
        push_alloc(16'd1);
        push_alloc(16'd8);
        push_alloc(16'd9);
        push_alloc(16'd2040);
        push_alloc(16'd4087);
        push_alloc(16'd4088);
        push_alloc(16'hFFFF);
        wait_idle();

        // Free, then reallocate from the list; free a big block twice so the
        // second free finds a link word where the size was.
        blk_small = live_blocks[0];
        blk_mid   = live_blocks[2];
        blk_big   = live_blocks[3];
        live_blocks = {live_blocks[1]};
        freed_blocks.push_back(blk_big);
        push_free(blk_small);
        push_alloc(16'd1);
        push_free(blk_big);
        push_free(blk_big);
        wait_idle();

        // With max_small lowered, freeing a block of a now rejected class is
        // ignored, and a request whose class reaches the limit is refused.
        write_reg(sfla_pkg::CFG_MAX_SMALL, 17'd32);
        push_free(blk_mid);
        push_alloc(16'd5);
        push_alloc(16'd9);
        wait_idle();
        live_blocks.push_back(blk_mid);

        // Lowest max_small: nothing fits.
        write_reg(sfla_pkg::CFG_MAX_SMALL, 17'd16);
        push_alloc(16'd1);
        wait_idle();

        // Base of zero turns into eight; a tiny region runs out of space.
        write_reg(sfla_pkg::CFG_MAX_SMALL, 17'd16384);
        write_reg(sfla_pkg::CFG_HEAP_BASE, 17'd0);
        write_reg(sfla_pkg::CFG_HEAP_END, 17'd100);
        push_alloc(16'd56);
        push_alloc(16'd56);
        push_alloc(16'd10);
        push_alloc(16'd4);
        wait_idle();

        // Unaligned base loses its low bits; largest class allowed and the
        // first ones past it.
        write_reg(sfla_pkg::CFG_HEAP_BASE, 17'h3005);
        write_reg(sfla_pkg::CFG_HEAP_END, 17'd65536);
        push_alloc(16'd8184);
        push_alloc(16'd8185);
        push_alloc(16'd16376);
        wait_idle();

        // Random part in rounds, each under its own register setting.
        // Requests go out in short batches so that frees can name blocks
        // whose allocation has already been predicted; now and then the
        // sender holds off until every result is back.
        for (round = 0; round < 9; round++) begin
            if (round == 0)
                write_reg(sfla_pkg::CFG_MAX_SMALL, 17'd4096);
            else if (round == 1)
                write_reg(sfla_pkg::CFG_MAX_SMALL, 17'd16384);
            else if ($urandom_range(0, 1) == 0)
                write_reg(sfla_pkg::CFG_MAX_SMALL, 17'(1 << $urandom_range(6, 14)));
            else
                write_reg(sfla_pkg::CFG_MAX_SMALL, 17'($urandom_range(16, 16384)));

            base_val = (round == 0) ? 4096 : $urandom_range(8, 49152);
            write_reg(sfla_pkg::CFG_HEAP_BASE, 17'(base_val));

            if (round == 8)
                end_val = $urandom_range(8, 65536);
            else if ($urandom_range(0, 2) == 0)
                end_val = base_val + $urandom_range(512, 8192);
            else
                end_val = 65536;
            if (end_val > 65536) end_val = 65536;
            write_reg(sfla_pkg::CFG_HEAP_END, 17'(end_val));

            steady = ($urandom_range(0, 3) == 0);
            n = 0;
            while (n < 150) begin
                if ($urandom_range(0, 9) == 0)
                    wait_idle();
                else
                    wait_requests_taken();
                batch = $urandom_range(1, 12);
                for (j = 0; j < batch && n < 150; j++) begin
                    add_random_request();
                    n++;
                end
            end
            wait_idle();
            steady = 1'b0;
        end

        // Everything answered; give a stray result word time to show up.
        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog for a hung handshake or a missing result.
    initial begin
        #12_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
